/* rtl/brm_pkg.sv */
package brm_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned REG_COUNT = 4;
  localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned CODE_W    = 4;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [1:0]           CLS_ARITH = 2'b10;
  localparam logic [1:0]           CLS_IO    = 2'b11;
  localparam logic [CODE_W-1:0]    IO_IN     = 4'h0;
  localparam logic [CODE_W-1:0]    IO_OUT    = 4'h1;
  localparam logic [REG_IDX_W-1:0] REG_D     = 2'd3;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_OUT     = 2'd1,
    STS_ILLEGAL = 2'd2,
    STS_DIVZERO = 2'd3
  } brm_status_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } brm_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DFIN
  } brm_state_e;

  typedef struct packed {
    logic accept;
    logic commit_exec;
    logic div_start;
    logic div_step;
    logic commit_div;
  } brm_cmd_t;

  typedef struct packed {
    logic div_go;
    logic div_last;
  } brm_sts_t;

  // Register read by port A: D for load immediate, rr for in/out, dst for arithmetic.
  function automatic logic [REG_IDX_W-1:0] addr_a(input logic [DATA_W-1:0] insn);
    logic [REG_IDX_W-1:0] a;
    if (!insn[7]) begin
      a = REG_D;
    end else if (insn[7:6] == CLS_IO) begin
      a = insn[1:0];
    end else begin
      a = insn[3:2];
    end
    return a;
  endfunction

endpackage

/* rtl/brm_ram.sv */
module brm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/brm_ctrl.sv */
module brm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  brm_pkg::brm_sts_t sts_i,
  output brm_pkg::brm_cmd_t cmd_o
);

  brm_pkg::brm_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      brm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = brm_pkg::ST_EXEC;
        end
      end
      brm_pkg::ST_EXEC: begin
        if (sts_i.div_go) begin
          cmd_o.div_start = 1'b1;
          state_d         = brm_pkg::ST_DIV;
        end else if (out_free) begin
          cmd_o.commit_exec = 1'b1;
          state_d           = brm_pkg::ST_IDLE;
        end
      end
      brm_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = brm_pkg::ST_DFIN;
        end
      end
      brm_pkg::ST_DFIN: begin
        if (out_free) begin
          cmd_o.commit_div = 1'b1;
          state_d          = brm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = brm_pkg::ST_IDLE;
      end
    endcase

    if (cmd_o.commit_exec || cmd_o.commit_div) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

endmodule

/* rtl/brm_dp.sv */
module brm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brm_pkg::brm_cmd_t             cmd_i,
  output brm_pkg::brm_sts_t             sts_o,
  input  logic [brm_pkg::DATA_W-1:0]    instruction_i,
  input  logic [brm_pkg::DATA_W-1:0]    in_value_i,
  output brm_pkg::brm_status_e          status_o,
  output logic [brm_pkg::DATA_W-1:0]    out_value_o
);

  localparam int unsigned W = brm_pkg::DATA_W;

  logic [W-1:0]                   instr_q, inval_q;
  logic [brm_pkg::REG_COUNT-1:0]  vld_q, vld_d;
  logic                           rd_vld_a_q, rd_vld_b_q;
  logic [brm_pkg::REG_IDX_W-1:0]  raddr_a, raddr_b;
  logic [W-1:0]                   ram_a, ram_b, opa, opb;

  logic                           we;
  logic [brm_pkg::REG_IDX_W-1:0]  waddr;
  logic [W-1:0]                   wdata;

  logic [W-1:0]                   quo_q, quo_d, rem_q, rem_d, dvs_q;
  logic [W:0]                     rem_sh, rem_sub;
  logic [brm_pkg::DIV_CNT_W-1:0]  cnt_q;

  logic [2*W-1:0]                 prod;
  brm_pkg::brm_op_e               op;
  logic [brm_pkg::CODE_W-1:0]     code;
  brm_pkg::brm_status_e           ex_status, res_status_q;
  logic [W-1:0]                   ex_value, res_value_q;

  // Register file: valid bits give the zero reset value.
  assign raddr_a = cmd_i.accept ? brm_pkg::addr_a(instruction_i) : brm_pkg::addr_a(instr_q);
  assign raddr_b = cmd_i.accept ? instruction_i[1:0] : instr_q[1:0];

  brm_ram #(
    .WIDTH (W),
    .DEPTH (brm_pkg::REG_COUNT)
  ) u_rf (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  assign opa = rd_vld_a_q ? ram_a : '0;
  assign opb = rd_vld_b_q ? ram_b : '0;

  always_comb begin
    vld_d = vld_q;
    if (we) begin
      vld_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_vld_a_q <= vld_q[raddr_a];
    rd_vld_b_q <= vld_q[raddr_b];
    if (cmd_i.accept) begin
      instr_q <= instruction_i;
      inval_q <= in_value_i;
    end
  end

  // Decode and execute
  assign op   = brm_pkg::brm_op_e'(instr_q[5:4]);
  assign code = instr_q[5:2];
  assign prod = opa * opb;

  assign sts_o.div_go   = (instr_q[7:6] == brm_pkg::CLS_ARITH) && (op == brm_pkg::OP_DIV)
                          && (opb != '0);
  assign sts_o.div_last = (cnt_q == brm_pkg::DIV_CNT_W'(brm_pkg::DIV_STEPS - 1));

  always_comb begin
    we        = 1'b0;
    waddr     = brm_pkg::addr_a(instr_q);
    wdata     = '0;
    ex_status = brm_pkg::STS_DONE;
    ex_value  = '0;
    if (cmd_i.commit_div) begin
      we    = 1'b1;
      wdata = quo_q;
    end else if (cmd_i.commit_exec) begin
      if (!instr_q[7]) begin
        we    = 1'b1;
        wdata = {1'b0, instr_q[W-2:0]};
      end else if (instr_q[7:6] == brm_pkg::CLS_IO) begin
        if (code == brm_pkg::IO_IN) begin
          we    = 1'b1;
          wdata = inval_q;
        end else if (code == brm_pkg::IO_OUT) begin
          ex_status = brm_pkg::STS_OUT;
          ex_value  = opa;
        end else begin
          ex_status = brm_pkg::STS_ILLEGAL;
        end
      end else begin
        case (op)
          brm_pkg::OP_ADD: begin
            we    = 1'b1;
            wdata = opa + opb;
          end
          brm_pkg::OP_SUB: begin
            we    = 1'b1;
            wdata = opa - opb;
          end
          brm_pkg::OP_MUL: begin
            we    = 1'b1;
            wdata = prod[W-1:0];
          end
          default: begin
            ex_status = brm_pkg::STS_DIVZERO;
          end
        endcase
      end
    end
  end

  // Restoring divider, one quotient bit per step
  assign rem_sh  = {rem_q, quo_q[W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    if (!rem_sub[W]) begin
      rem_d = rem_sub[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= opa;
      rem_q <= '0;
      dvs_q <= opb;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_exec || cmd_i.commit_div) begin
      res_status_q <= ex_status;
      res_value_q  <= ex_value;
    end
  end

  assign status_o    = res_status_q;
  assign out_value_o = res_value_q;

endmodule

/* rtl/byte_register_machine_execute.sv */
// Byte register machine: executes one instruction byte per input transaction on four
// 8-bit registers that reset to zero, and returns one result transaction per input
// (status, plus the register value for OUT). One instruction is in flight at a time.
// Load immediate, IN, OUT, ADD, SUB, MUL and divide by zero read the register file in the
// accepting cycle, then execute and write back, registering the result into the output
// register. DIV with a nonzero divisor goes through read, divider load, the bit-serial
// restoring divider (one quotient bit per cycle for all 8 bits), then write back.
// The next transaction is accepted the cycle after a result is produced, even while
// that result waits in the output register; execution stalls only if the output
// register is still occupied when the following result is ready.
module byte_register_machine_execute (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [brm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // instruction[7:0], in_value[15:8]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [brm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // status[1:0], out_value[9:2], zero
);

  brm_pkg::brm_cmd_t                 cmd;
  brm_pkg::brm_sts_t                 sts;
  brm_pkg::brm_status_e              status;
  logic [brm_pkg::DATA_W-1:0]        out_value;

  brm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .instruction_i (s_axis_tdata[brm_pkg::DATA_W-1:0]),
    .in_value_i    (s_axis_tdata[2*brm_pkg::DATA_W-1:brm_pkg::DATA_W]),
    .status_o      (status),
    .out_value_o   (out_value)
  );

  assign m_axis_tdata = brm_pkg::OUT_TDATA_W'({out_value, status});

endmodule

/* rtl/brm_chk.sv */
module brm_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [brm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned PAY_W = 2 + brm_pkg::DATA_W;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second instruction accepted while one is executing");

  a_no_result_without_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid
    || $past(m_axis_tvalid && !m_axis_tready))
    else $error("result valid right after acceptance without a held earlier result");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != brm_pkg::STS_OUT)
    |-> m_axis_tdata[PAY_W-1:2] == '0)
    else $error("out_value nonzero for a status other than OUT");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[brm_pkg::OUT_TDATA_W-1:PAY_W] == '0)
    else $error("result padding bits not zero");

endmodule

bind byte_register_machine_execute brm_chk u_brm_chk (.*);
